// File: design/kmd_pkg.sv
// Package for the k-nearest mean distance block.
// Holds the shared constants and the controller-to-datapath command type.
// No dependencies.
package kmd_pkg;

    localparam int K_MAX_DEF     = 16;
    localparam int DIST_BITS_DEF = 32;
    localparam int NC_BITS       = 5;
    localparam int IN_BITS       = 32;
    localparam int OUT_BITS      = 32;

    typedef struct packed {
        logic load_item;
        logic wr_fill;
        logic wr_replace;
        logic cmp_first;
        logic cmp_en;
        logic acc_clear;
        logic acc_add;
        logic div_step;
        logic out_load;
        logic out_short;
    } cmd_t;

endpackage

// File: design/kmd_ctrl.sv
// Controller of the k-nearest mean distance block: state machine, row counter,
// neighbour count register and scan counters. Depends on kmd_pkg.
module kmd_ctrl #(
    parameter int K_MAX     = kmd_pkg::K_MAX_DEF,
    parameter int DIST_BITS = kmd_pkg::DIST_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kmd_pkg::NC_BITS-1:0]    cfg_neighbour_count,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_last_in_row,
    input  logic                           out_free,
    output kmd_pkg::cmd_t                  cmd,
    output logic [$clog2(K_MAX+1)-1:0]     k,
    output logic [((K_MAX > 1) ? $clog2(K_MAX) : 1)-1:0] rd_addr,
    output logic [((K_MAX > 1) ? $clog2(K_MAX) : 1)-1:0] cmp_addr,
    output logic [((K_MAX > 1) ? $clog2(K_MAX) : 1)-1:0] fill_addr
);

    localparam int CW       = $clog2(K_MAX + 1);
    localparam int AW       = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int SUM_BITS = DIST_BITS + $clog2(K_MAX);
    localparam int DW       = $clog2(SUM_BITS);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN    = 6'b000010,
        S_REPLACE = 6'b000100,
        S_SUM     = 6'b001000,
        S_DIV     = 6'b010000,
        S_EMIT    = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [kmd_pkg::NC_BITS-1:0]  nc_reg;
    logic [CW-1:0]                seen_reg, seen_next;
    logic [CW-1:0]                k_reg, k_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic [DW-1:0]                cnt_reg, cnt_next;
    logic                         last_reg, last_next;
    logic                         short_reg, short_next;
    logic [CW-1:0]                k_eff;
    logic [CW-1:0]                seen_inc;

    always_comb begin
        if (nc_reg == '0) begin
            k_eff = CW'(1);
        end else if (32'(nc_reg) > K_MAX) begin
            k_eff = CW'(K_MAX);
        end else begin
            k_eff = CW'(nc_reg);
        end
    end

    assign seen_inc = (seen_reg == CW'(K_MAX)) ? seen_reg : CW'(seen_reg + 1'b1);

    always_comb begin
        state_next = state_reg;
        seen_next  = seen_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        short_next = short_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    k_next        = k_eff;
                    last_next     = s_last_in_row;
                    short_next    = s_last_in_row && (seen_inc < k_eff);
                    seen_next     = s_last_in_row ? '0 : seen_inc;
                    idx_next      = '0;
                    if (seen_reg < k_eff) begin
                        cmd.wr_fill = 1'b1;
                        if (s_last_in_row) begin
                            state_next = (seen_inc < k_eff) ? S_EMIT : S_SUM;
                        end
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.cmp_first = (idx_reg == CW'(1));
                cmd.cmp_en    = (idx_reg > CW'(1));
                if (idx_reg == k_reg) begin
                    state_next = S_REPLACE;
                end else begin
                    idx_next = CW'(idx_reg + 1'b1);
                end
            end
            S_REPLACE: begin
                cmd.wr_replace = 1'b1;
                idx_next       = '0;
                if (last_reg) begin
                    state_next = short_reg ? S_EMIT : S_SUM;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_SUM: begin
                cmd.acc_clear = (idx_reg == '0);
                cmd.acc_add   = (idx_reg != '0);
                if (idx_reg == k_reg) begin
                    state_next = S_DIV;
                    cnt_next   = '0;
                end else begin
                    idx_next = CW'(idx_reg + 1'b1);
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DW'(SUM_BITS - 1)) begin
                    state_next = S_EMIT;
                end else begin
                    cnt_next = DW'(cnt_reg + 1'b1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_short = short_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            nc_reg    <= kmd_pkg::NC_BITS'(1);
            seen_reg  <= '0;
            k_reg     <= '0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            short_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            k_reg     <= k_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            short_reg <= short_next;
            if (cfg_valid) begin
                nc_reg <= cfg_neighbour_count;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign k         = k_reg;
    assign rd_addr   = idx_reg[AW-1:0];
    assign cmp_addr  = AW'(idx_reg - 1'b1);
    assign fill_addr = seen_reg[AW-1:0];

endmodule

// File: design/kmd_datapath.sv
// Datapath of the k-nearest mean distance block: kept-value memory, max search
// registers, row sum, radix-2 divider and output register. Depends on kmd_pkg.
module kmd_datapath #(
    parameter int K_MAX     = kmd_pkg::K_MAX_DEF,
    parameter int DIST_BITS = kmd_pkg::DIST_BITS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  kmd_pkg::cmd_t                                cmd,
    input  logic [$clog2(K_MAX+1)-1:0]                   k,
    input  logic [((K_MAX > 1) ? $clog2(K_MAX) : 1)-1:0] rd_addr,
    input  logic [((K_MAX > 1) ? $clog2(K_MAX) : 1)-1:0] cmp_addr,
    input  logic [((K_MAX > 1) ? $clog2(K_MAX) : 1)-1:0] fill_addr,
    input  logic [kmd_pkg::IN_BITS-1:0]                  s_distance,
    output logic                                         out_free,
    output logic                                         m_valid,
    input  logic                                         m_ready,
    output logic [kmd_pkg::OUT_BITS-1:0]                 m_mean_distance,
    output logic                                         m_row_too_short
);

    localparam int CW       = $clog2(K_MAX + 1);
    localparam int AW       = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int SUM_BITS = DIST_BITS + $clog2(K_MAX);

    logic [DIST_BITS-1:0]          mem [K_MAX];
    logic [DIST_BITS-1:0]          rd_data_reg;
    logic [DIST_BITS-1:0]          value_reg;
    logic [DIST_BITS-1:0]          big_reg;
    logic [AW-1:0]                 where_reg;
    logic [SUM_BITS-1:0]           acc_reg, acc_next;
    logic [CW-1:0]                 rem_reg, rem_next;
    logic                          out_valid_reg;
    logic [kmd_pkg::OUT_BITS-1:0]  mean_reg;
    logic                          short_reg;

    logic [DIST_BITS-1:0]          dist_in;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [DIST_BITS-1:0]          wr_data;
    logic [CW:0]                   rem_shift;
    logic [CW:0]                   rem_diff;
    logic                          quot_bit;

    assign dist_in = DIST_BITS'(s_distance);
    assign wr_en   = cmd.wr_fill || (cmd.wr_replace && (value_reg < big_reg));
    assign wr_addr = cmd.wr_fill ? fill_addr : where_reg;
    assign wr_data = cmd.wr_fill ? dist_in : value_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            value_reg <= dist_in;
        end
        if (cmd.cmp_first || (cmd.cmp_en && (rd_data_reg > big_reg))) begin
            big_reg   <= rd_data_reg;
            where_reg <= cmp_addr;
        end
    end

    assign rem_shift = {rem_reg, acc_reg[SUM_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, k};
    assign quot_bit  = (rem_shift >= {1'b0, k});

    always_comb begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        if (cmd.acc_clear) begin
            acc_next = '0;
            rem_next = '0;
        end else if (cmd.acc_add) begin
            acc_next = acc_reg + SUM_BITS'(rd_data_reg);
        end else if (cmd.div_step) begin
            acc_next = {acc_reg[SUM_BITS-2:0], quot_bit};
            rem_next = quot_bit ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            mean_reg  <= cmd.out_short ? '0 : kmd_pkg::OUT_BITS'(acc_reg);
            short_reg <= cmd.out_short;
        end
    end

    assign out_free        = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_mean_distance = mean_reg;
    assign m_row_too_short = short_reg;

endmodule

// File: design/k_nearest_mean_distance_top.sv
// Top level of the k-nearest mean distance block.
// Depends on kmd_pkg, kmd_ctrl and kmd_datapath.
//
// Usage: write the neighbour count k on the cfg channel while the block is idle
// (reset value 1; 0 acts as 1, values above K_MAX act as K_MAX). Send the
// distances of one row on the s_ channel, s_last_in_row high on the final one.
// The block keeps the k smallest distances of the row and, at the row end,
// emits one item on the m_ channel: the truncated mean of those k values, or a
// zero mean with m_row_too_short high when the row held fewer than k values.
// Operation: while the store fills, an item is written directly. Once k values are
// held, each item runs a one-entry-per-cycle max search over the kept-value memory
// (one read port, registered data), then replaces the largest if smaller; s_ready
// stays low until then. At the row end, the kept values are summed, the bit-serial
// divider runs and the output register is loaded.
// Reset clears the row count, the output valid and sets k to 1; the memory is
// not cleared. The output register holds a result until taken; the block keeps
// taking items and waits only when a second result is ready before the first
// has left.
module k_nearest_mean_distance_top #(
    parameter int K_MAX     = kmd_pkg::K_MAX_DEF,
    parameter int DIST_BITS = kmd_pkg::DIST_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kmd_pkg::NC_BITS-1:0]   cfg_neighbour_count,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [kmd_pkg::IN_BITS-1:0]   s_distance,
    input  logic                          s_last_in_row,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [kmd_pkg::OUT_BITS-1:0]  m_mean_distance,
    output logic                          m_row_too_short
);

    localparam int CW = $clog2(K_MAX + 1);
    localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

    kmd_pkg::cmd_t  cmd;
    logic           out_free;
    logic [CW-1:0]  k;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  cmp_addr;
    logic [AW-1:0]  fill_addr;

    kmd_ctrl #(
        .K_MAX     (K_MAX),
        .DIST_BITS (DIST_BITS)
    ) u_ctrl (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_neighbour_count (cfg_neighbour_count),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_last_in_row       (s_last_in_row),
        .out_free            (out_free),
        .cmd                 (cmd),
        .k                   (k),
        .rd_addr             (rd_addr),
        .cmp_addr            (cmp_addr),
        .fill_addr           (fill_addr)
    );

    kmd_datapath #(
        .K_MAX     (K_MAX),
        .DIST_BITS (DIST_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .k               (k),
        .rd_addr         (rd_addr),
        .cmp_addr        (cmp_addr),
        .fill_addr       (fill_addr),
        .s_distance      (s_distance),
        .out_free        (out_free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mean_distance (m_mean_distance),
        .m_row_too_short (m_row_too_short)
    );

endmodule
